FILE: sv/sba_pkg.sv
// Shared types, constants and helpers for the shared-buffer admission block.
package sba_pkg;

  localparam int NUM_QUEUES = 4;
  localparam int QIDX_W     = $clog2(NUM_QUEUES);
  localparam int QCNT_W     = $clog2(NUM_QUEUES + 1);

  localparam int ALPHA_W    = 20;
  localparam int DIVR_W     = 40;
  localparam int DEQ_W      = 48;
  localparam int RATE_W     = 17;
  localparam int DVD_W      = 64;
  localparam int QUO_W      = 32;
  localparam int STEP_W     = $clog2(QUO_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [QUO_W-1:0]  LIMIT_CAP = 32'd4294965795;
  localparam logic [RATE_W-1:0] RATE_ONE  = 17'd65536;
  localparam logic [DEQ_W-1:0]  DEQ_MAX   = '1;

  localparam logic [1:0] ACT_ARRIVE  = 2'd0;
  localparam logic [1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;

  localparam logic [1:0] MODE_DT  = 2'd0;
  localparam logic [1:0] MODE_ABM = 2'd1;
  localparam logic [1:0] MODE_CS  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q3    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_UNSCH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_DIV    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CNT   = 3'd7;

  typedef struct packed {
    logic [1:0]              mode;
    logic [3:0][ALPHA_W-1:0] alpha;
    logic [ALPHA_W-1:0]      alpha_unsched;
    logic [DIVR_W-1:0]       rate_divisor;
    logic [2:0]              queue_count;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             over;
    logic [QUO_W-1:0] quot;
  } div_res_t;

  function automatic logic [QIDX_W-1:0] clamp_queue(input logic [1:0] qi);
    if (int'(qi) >= NUM_QUEUES) return QIDX_W'(NUM_QUEUES - 1);
    return QIDX_W'(qi);
  endfunction

endpackage

FILE: sv/shared_buffer_admission_top.sv
// Top level of the shared-buffer admission block: sequencer, per-queue state and output beat.
// One beat is taken at a time; in_stall stays high until its work is finished. A dequeue
// report is handled in the idle state. An arrival check in dynamic-threshold mode, and after
// an extra multiply step in active-buffer-management mode, uses the shared divider that
// yields one quotient bit per cycle over 32 bits; the division stops at its start when the
// quotient overflows 32 bits, and the divider is skipped in complete-sharing mode or with a
// zero divisor. The check also waits while the previous result still holds the output
// register. A rate tick runs a division for each refreshed queue that needs one and skips it
// for one whose rate is forced to 1.0. The finished result waits in an output register, so a
// new input beat is taken while the previous result is still stalled.
module shared_buffer_admission_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic [1:0]                      in_queue_index,
  input  logic [15:0]                     in_packet_bytes,
  input  logic [31:0]                     in_queue_bytes,
  input  logic [31:0]                     in_remaining_bytes,
  input  logic [31:0]                     in_shared_bytes,
  input  logic [7:0]                      in_congested_queues,
  input  logic                            in_unscheduled,
  input  logic [15:0]                     in_departed_bytes,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_accept,
  output logic [31:0]                     out_threshold_bytes,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sba_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL1   = 8'b0000_0010,
    S_MUL2   = 8'b0000_0100,
    S_DSTART = 8'b0000_1000,
    S_DWAIT  = 8'b0001_0000,
    S_OUT    = 8'b0010_0000,
    S_TCHK   = 8'b0100_0000,
    S_TWAIT  = 8'b1000_0000
  } state_t;

  sba_pkg::cfg_t     cfg;
  sba_pkg::div_req_t dreq;
  sba_pkg::div_res_t dres;

  state_t                       state_r, state_nxt;
  logic [sba_pkg::QIDX_W-1:0]   q_r, q_nxt;
  logic [15:0]                  pkt_r, pkt_nxt;
  logic [31:0]                  qbytes_r, qbytes_nxt;
  logic [31:0]                  remain_r, remain_nxt;
  logic [31:0]                  shared_r, shared_nxt;
  logic [7:0]                   cong_r, cong_nxt;
  logic                         unsch_r, unsch_nxt;
  logic [31:0]                  limit_r, limit_nxt;
  logic                         cs_r, cs_nxt;
  logic [51:0]                  prod1_r, prod1_nxt;
  logic [68:0]                  prod2_r, prod2_nxt;
  logic [sba_pkg::QIDX_W-1:0]   p_r, p_nxt;
  logic [sba_pkg::QCNT_W-1:0]   neff_r, neff_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_acc_r, out_acc_nxt;
  logic [31:0]                  out_thr_r, out_thr_nxt;

  logic [sba_pkg::DEQ_W-1:0]    deq_r [sba_pkg::NUM_QUEUES];
  logic [sba_pkg::RATE_W-1:0]   rate_r [sba_pkg::NUM_QUEUES];

  logic                         in_acc;
  logic [sba_pkg::QIDX_W-1:0]   in_q_cl;
  logic [sba_pkg::QIDX_W-1:0]   deq_addr;
  logic [sba_pkg::DEQ_W-1:0]    deq_rd;
  logic                         deq_we;
  logic [sba_pkg::DEQ_W-1:0]    deq_wd;
  logic                         rate_we;
  logic [sba_pkg::RATE_W-1:0]   rate_wd;
  logic [sba_pkg::DEQ_W:0]      deq_sum;
  logic [50:0]                  b8;
  logic [53:0]                  b8_qc;
  logic                         force_one;
  logic [sba_pkg::QCNT_W-1:0]   n_eff;
  logic                         tick_last;
  logic                         is_abm;
  logic                         is_cs;
  logic [sba_pkg::ALPHA_W:0]    alpha_sum;
  logic [sba_pkg::ALPHA_W-1:0]  alpha_sel;
  logic [31:0]                  operand;
  logic                         room;
  logic [32:0]                  need;
  logic                         out_load;

  sba_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .res   (dres)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_q_cl  = sba_pkg::clamp_queue(in_queue_index);

  assign deq_addr = (state_r == S_IDLE) ? in_q_cl : p_r;
  assign deq_rd   = deq_r[deq_addr];
  assign deq_sum  = {1'b0, deq_rd} + (sba_pkg::DEQ_W + 1)'(in_departed_bytes);

  assign b8        = {deq_rd, 3'b000};
  assign b8_qc     = 54'(b8) * 54'(cfg.queue_count);
  assign force_one = (cfg.rate_divisor == '0) || (b8 > 51'(cfg.rate_divisor))
                     || (b8_qc < 54'(cfg.rate_divisor));
  assign n_eff     = (int'(cfg.queue_count) > sba_pkg::NUM_QUEUES)
                     ? sba_pkg::QCNT_W'(sba_pkg::NUM_QUEUES)
                     : sba_pkg::QCNT_W'(cfg.queue_count);
  assign tick_last = (sba_pkg::QCNT_W'(p_r) + sba_pkg::QCNT_W'(1)) == neff_r;

  assign is_abm    = (cfg.mode == sba_pkg::MODE_ABM);
  assign is_cs     = (cfg.mode == sba_pkg::MODE_CS);
  assign alpha_sum = {1'b0, cfg.alpha[0]} + {1'b0, cfg.alpha[1]};
  assign alpha_sel = (is_abm && unsch_r) ? cfg.alpha_unsched : cfg.alpha[2'(q_r)];
  assign operand   = is_abm ? remain_r : shared_r;

  assign room     = remain_r >= {16'b0, pkt_r};
  assign need     = {1'b0, qbytes_r} + {17'b0, pkt_r};
  assign out_load = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    pkt_nxt       = pkt_r;
    qbytes_nxt    = qbytes_r;
    remain_nxt    = remain_r;
    shared_nxt    = shared_r;
    cong_nxt      = cong_r;
    unsch_nxt     = unsch_r;
    limit_nxt     = limit_r;
    cs_nxt        = cs_r;
    prod1_nxt     = prod1_r;
    prod2_nxt     = prod2_r;
    p_nxt         = p_r;
    neff_nxt      = neff_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_acc_nxt   = out_acc_r;
    out_thr_nxt   = out_thr_r;
    deq_we        = 1'b0;
    deq_wd        = '0;
    rate_we       = 1'b0;
    rate_wd       = sba_pkg::RATE_ONE;
    dreq          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          q_nxt      = in_q_cl;
          pkt_nxt    = in_packet_bytes;
          qbytes_nxt = in_queue_bytes;
          remain_nxt = in_remaining_bytes;
          shared_nxt = in_shared_bytes;
          cong_nxt   = in_congested_queues;
          unsch_nxt  = in_unscheduled;
          unique case (in_action)
            sba_pkg::ACT_ARRIVE: state_nxt = S_MUL1;
            sba_pkg::ACT_DEQUEUE: begin
              deq_we = 1'b1;
              deq_wd = deq_sum[sba_pkg::DEQ_W] ? sba_pkg::DEQ_MAX
                                               : deq_sum[sba_pkg::DEQ_W-1:0];
            end
            sba_pkg::ACT_TICK: begin
              neff_nxt = n_eff;
              p_nxt    = '0;
              if (n_eff != '0) state_nxt = S_TCHK;
            end
            default: ;
          endcase
        end
      end
      S_MUL1: begin
        prod1_nxt = 52'(alpha_sel) * 52'(operand);
        cs_nxt    = is_cs;
        if (is_cs) begin
          limit_nxt = '0;
          state_nxt = S_OUT;
        end else if (is_abm ? (cong_r == '0) : (alpha_sum == '0)) begin
          limit_nxt = sba_pkg::LIMIT_CAP;
          state_nxt = S_OUT;
        end else begin
          state_nxt = is_abm ? S_MUL2 : S_DSTART;
        end
      end
      S_MUL2: begin
        prod2_nxt = 69'(prod1_r) * 69'(rate_r[q_r]);
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        dreq.start    = 1'b1;
        dreq.dividend = is_abm ? sba_pkg::DVD_W'(prod2_r[68:24]) : sba_pkg::DVD_W'(prod1_r);
        dreq.divisor  = is_abm ? sba_pkg::DIVR_W'(cong_r) : sba_pkg::DIVR_W'(alpha_sum);
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (dres.done) begin
          limit_nxt = dres.over ? sba_pkg::LIMIT_CAP : dres.quot;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = room && (cs_r || (need <= {1'b0, limit_r}));
          out_thr_nxt   = limit_r;
          state_nxt     = S_IDLE;
        end
      end
      S_TCHK: begin
        if (force_one) begin
          rate_we = 1'b1;
          rate_wd = sba_pkg::RATE_ONE;
          deq_we  = 1'b1;
          deq_wd  = '0;
          p_nxt   = p_r + 1'b1;
          if (tick_last) state_nxt = S_IDLE;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = {b8[47:0], 16'b0};
          dreq.divisor  = cfg.rate_divisor;
          state_nxt     = S_TWAIT;
        end
      end
      S_TWAIT: begin
        if (dres.done) begin
          rate_we   = 1'b1;
          rate_wd   = dres.quot[sba_pkg::RATE_W-1:0];
          deq_we    = 1'b1;
          deq_wd    = '0;
          p_nxt     = p_r + 1'b1;
          state_nxt = tick_last ? S_IDLE : S_TCHK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_r         <= '0;
      neff_r      <= '0;
      for (int i = 0; i < sba_pkg::NUM_QUEUES; i++) begin
        deq_r[i]  <= '0;
        rate_r[i] <= sba_pkg::RATE_ONE;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      p_r         <= p_nxt;
      neff_r      <= neff_nxt;
      if (deq_we) deq_r[deq_addr] <= deq_wd;
      if (rate_we) rate_r[p_r] <= rate_wd;
    end
  end

  always_ff @(posedge clk) begin
    q_r       <= q_nxt;
    pkt_r     <= pkt_nxt;
    qbytes_r  <= qbytes_nxt;
    remain_r  <= remain_nxt;
    shared_r  <= shared_nxt;
    cong_r    <= cong_nxt;
    unsch_r   <= unsch_nxt;
    limit_r   <= limit_nxt;
    cs_r      <= cs_nxt;
    prod1_r   <= prod1_nxt;
    prod2_r   <= prod2_nxt;
    out_acc_r <= out_acc_nxt;
    out_thr_r <= out_thr_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_accept          = out_acc_r;
  assign out_threshold_bytes = out_thr_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> !dres.busy)
    else $error("divider started while busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dres.done |-> (state_r == S_DWAIT || state_r == S_TWAIT))
    else $error("divider result with no consumer");

  a_tick_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TWAIT && dres.done) |->
      (!dres.over && dres.quot <= sba_pkg::QUO_W'(sba_pkg::RATE_ONE)))
    else $error("dequeue rate above 1.0");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT))
    else $error("result beat raised outside output state");

endmodule

FILE: sv/sba_cfg.sv
// Configuration register bank for the shared-buffer admission block.
module sba_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sba_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sba_pkg::cfg_t                   cfg
);

  sba_pkg::cfg_t cfg_r;
  sba_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        sba_pkg::CFG_MODE:        cfg_nxt.mode          = cfg_data[1:0];
        sba_pkg::CFG_ALPHA_Q0:    cfg_nxt.alpha[0]      = cfg_data[sba_pkg::ALPHA_W-1:0];
        sba_pkg::CFG_ALPHA_Q1:    cfg_nxt.alpha[1]      = cfg_data[sba_pkg::ALPHA_W-1:0];
        sba_pkg::CFG_ALPHA_Q2:    cfg_nxt.alpha[2]      = cfg_data[sba_pkg::ALPHA_W-1:0];
        sba_pkg::CFG_ALPHA_Q3:    cfg_nxt.alpha[3]      = cfg_data[sba_pkg::ALPHA_W-1:0];
        sba_pkg::CFG_ALPHA_UNSCH: cfg_nxt.alpha_unsched = cfg_data[sba_pkg::ALPHA_W-1:0];
        sba_pkg::CFG_RATE_DIV:    cfg_nxt.rate_divisor  = cfg_data[sba_pkg::DIVR_W-1:0];
        sba_pkg::CFG_QUEUE_CNT:   cfg_nxt.queue_count   = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= sba_pkg::MODE_DT;
      cfg_r.alpha         <= {4{20'd256}};
      cfg_r.alpha_unsched <= 20'd262144;
      cfg_r.rate_divisor  <= 40'd300000;
      cfg_r.queue_count   <= 3'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/sba_div.sv
// Shared restoring divider, one quotient bit per cycle, with quotient overflow flag.
module sba_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sba_pkg::div_req_t req,
  output sba_pkg::div_res_t res
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic                        over_r, over_nxt;
  logic [sba_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [sba_pkg::DIVR_W-1:0]  rem_r, rem_nxt;
  logic [sba_pkg::DIVR_W-1:0]  dvs_r, dvs_nxt;
  logic [sba_pkg::QUO_W-1:0]   lo_r, lo_nxt;
  logic [sba_pkg::DIVR_W:0]    trial;
  logic [sba_pkg::DIVR_W:0]    diff;
  logic                        ge;
  logic [sba_pkg::DIVR_W-1:0]  hi_part;

  assign hi_part = sba_pkg::DIVR_W'(req.dividend[sba_pkg::DVD_W-1:sba_pkg::QUO_W]);
  assign trial   = {rem_r, lo_r[sba_pkg::QUO_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign ge      = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    over_nxt = over_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    lo_nxt   = lo_r;
    if (req.start) begin
      dvs_nxt  = req.divisor;
      rem_nxt  = hi_part;
      lo_nxt   = req.dividend[sba_pkg::QUO_W-1:0];
      cnt_nxt  = '0;
      over_nxt = hi_part >= req.divisor;
      busy_nxt = !(hi_part >= req.divisor);
      done_nxt = hi_part >= req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[sba_pkg::DIVR_W-1:0] : trial[sba_pkg::DIVR_W-1:0];
      lo_nxt  = {lo_r[sba_pkg::QUO_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sba_pkg::STEP_W'(sba_pkg::QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      over_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      over_r <= over_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    lo_r  <= lo_nxt;
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.over = over_r;
  assign res.quot = lo_r;

endmodule
